// ----- hdl/counting_semaphore_table_unit_macros.svh -----
// assertion macros for the counting semaphore table unit
`ifndef COUNTING_SEMAPHORE_TABLE_UNIT_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define CSU_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csu assertion failed");
// next-cycle implication, disabled during reset
`define CSU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csu assertion failed");
`else
`define CSU_ASSERT_IMPLY(lbl, ante, cons)
`define CSU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/csu_pkg.sv -----
// shared constants and types of the counting semaphore table unit
`timescale 1ns / 1ps
package csu_pkg;

   localparam int NUM_SLOTS   = 16;
   localparam int MAX_WAITERS = 8;

   localparam int KEY_W = 16;
   localparam int CNT_W = 16;
   localparam int PID_W = 16;

   localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int LW  = $clog2(MAX_WAITERS + 1);
   localparam int QW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int WAW = (NUM_SLOTS * MAX_WAITERS > 1) ? $clog2(NUM_SLOTS * MAX_WAITERS) : 1;

   localparam logic [1:0] KIND_OPEN  = 2'd0;
   localparam logic [1:0] KIND_WAIT  = 2'd1;
   localparam logic [1:0] KIND_POST  = 2'd2;
   localparam logic [1:0] KIND_CLOSE = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
   localparam logic [1:0] ST_NO_SPACE   = 2'd2;
   localparam logic [1:0] ST_TABLE_FULL = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [KEY_W-1:0] sem_key;
      logic [CNT_W-1:0] init_value;
      logic [PID_W-1:0] caller_pid;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             must_block;
      logic             wake_valid;
      logic [PID_W-1:0] wake_pid;
      logic [CNT_W-1:0] count_after;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [LW-1:0]    listeners;
      logic [LW-1:0]    waiting;
      logic [QW-1:0]    head;
   } slot_entry_type;

   typedef struct packed {
      logic load_req;
      logic lookup;
      logic fetch;
      logic commit;
   } cmd_type;

endpackage

// ----- hdl/csu_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module csu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/csu_ctrl.sv -----
// sequencer for one request: lookup, slot read, queue read, commit, respond
`timescale 1ns / 1ps
`include "counting_semaphore_table_unit_macros.svh"
module csu_ctrl import csu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LOOK = 5'b00010,
      S_READ = 5'b00100,
      S_EXEC = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_READ;
         end
         S_READ: begin
            cmd.fetch = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            cmd.commit = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   `CSU_ASSERT_NEXT(a_accept_starts_lookup, req_valid && !req_stall, cmd.lookup)
   `CSU_ASSERT_NEXT(a_commit_shows_item, cmd.commit, rsp_valid)
   `CSU_ASSERT_IMPLY(a_one_in_flight, rsp_valid, req_stall)

endmodule

// ----- hdl/csu_dp.sv -----
// key table, slot record ram, waiter ram and result register
`timescale 1ns / 1ps
`include "counting_semaphore_table_unit_macros.svh"
module csu_dp import csu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam logic [LW:0]   MW_SUM = (LW + 1)'(MAX_WAITERS);
   localparam logic [LW-1:0] MW_LIM = LW'(MAX_WAITERS);
   localparam logic [QW:0]   MW_HEAD = (QW + 1)'(MAX_WAITERS);

   req_type              req_ff;
   logic [KEY_W-1:0]     key_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] used_ff;
   logic [SW-1:0]        slot_ff;
   logic                 hit_ff;
   logic                 found_ff;
   slot_entry_type       entry_ff;
   rsp_type              rsp_ff;

   logic           hit, free_ok;
   logic [SW-1:0]  match_idx, free_idx;
   slot_entry_type slot_rd;
   logic [PID_W-1:0] wtr_rd;
   slot_entry_type entry_in;

   // commit side
   rsp_type        rsp_in;
   slot_entry_type ent_new;
   logic           slot_we, wtr_we, alloc, release_slot;
   logic [QW-1:0]  pos;
   logic [WAW-1:0] wtr_rd_addr, wtr_wr_addr;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // lowest used slot with the key, lowest free slot
   always_comb begin
      hit       = 1'b0;
      free_ok   = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (used_ff[i] && key_ff[i] == req_ff.sem_key) begin
            hit       = 1'b1;
            match_idx = SW'(i);
         end
         if (!used_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         slot_ff  <= hit ? match_idx : free_idx;
         hit_ff   <= hit;
         found_ff <= hit || free_ok;
      end
      if (cmd.fetch) begin
         entry_ff <= entry_in;
      end
   end

   // fresh record when open allocates
   always_comb begin
      if (hit_ff) begin
         entry_in = slot_rd;
      end else begin
         entry_in.count     = req_ff.init_value;
         entry_in.listeners = '0;
         entry_in.waiting   = '0;
         entry_in.head      = '0;
      end
   end

   assign wtr_rd_addr = WAW'(int'(slot_ff) * MAX_WAITERS + int'(entry_in.head));

   csu_ram #(
      .WIDTH($bits(slot_entry_type)),
      .DEPTH(NUM_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_we),
      .wr_addr(slot_ff),
      .wr_data(ent_new),
      .rd_en  (cmd.lookup),
      .rd_addr(hit ? match_idx : free_idx),
      .rd_data(slot_rd)
   );

   csu_ram #(
      .WIDTH(PID_W),
      .DEPTH(NUM_SLOTS * MAX_WAITERS)
   ) u_wtr_ram (
      .clock  (clock),
      .wr_en  (wtr_we),
      .wr_addr(wtr_wr_addr),
      .wr_data(req_ff.caller_pid),
      .rd_en  (cmd.fetch),
      .rd_addr(wtr_rd_addr),
      .rd_data(wtr_rd)
   );

   always_comb begin
      logic [LW:0] tail_sum;
      logic [QW:0] head_inc;
      tail_sum     = (LW + 1)'(entry_ff.head) + (LW + 1)'(entry_ff.waiting);
      pos          = (tail_sum >= MW_SUM) ? QW'(tail_sum - MW_SUM) : QW'(tail_sum);
      head_inc     = (QW + 1)'(entry_ff.head) + (QW + 1)'(1);
      wtr_wr_addr  = WAW'(int'(slot_ff) * MAX_WAITERS + int'(pos));
      ent_new      = entry_ff;
      rsp_in       = '0;
      slot_we      = 1'b0;
      wtr_we       = 1'b0;
      alloc        = 1'b0;
      release_slot = 1'b0;
      if (req_ff.kind == KIND_OPEN) begin
         if (!found_ff) begin
            rsp_in.status = ST_TABLE_FULL;
         end else begin
            alloc = !hit_ff;
            if (entry_ff.listeners >= MW_LIM) begin
               rsp_in.status = ST_NO_SPACE;
            end else begin
               ent_new.listeners = entry_ff.listeners + LW'(1);
               slot_we           = 1'b1;
            end
            rsp_in.count_after = entry_ff.count;
         end
      end else if (!hit_ff) begin
         rsp_in.status = ST_NOT_FOUND;
      end else begin
         case (req_ff.kind)
            KIND_WAIT: begin
               if (entry_ff.count != '0) begin
                  ent_new.count = entry_ff.count - CNT_W'(1);
                  slot_we       = 1'b1;
               end else if (entry_ff.waiting >= MW_LIM) begin
                  rsp_in.status = ST_NO_SPACE;
               end else begin
                  ent_new.waiting   = entry_ff.waiting + LW'(1);
                  slot_we           = 1'b1;
                  wtr_we            = 1'b1;
                  rsp_in.must_block = 1'b1;
               end
               rsp_in.count_after = ent_new.count;
            end
            KIND_POST: begin
               if (entry_ff.waiting != '0) begin
                  rsp_in.wake_valid = 1'b1;
                  rsp_in.wake_pid   = wtr_rd;
                  ent_new.head      = (head_inc >= MW_HEAD) ? '0 : QW'(head_inc);
                  ent_new.waiting   = entry_ff.waiting - LW'(1);
                  slot_we           = 1'b1;
               end else if (entry_ff.count != '1) begin
                  ent_new.count = entry_ff.count + CNT_W'(1);
                  slot_we       = 1'b1;
               end
               rsp_in.count_after = ent_new.count;
            end
            default: begin
               if (entry_ff.listeners <= LW'(1)) begin
                  release_slot = 1'b1;
               end else begin
                  ent_new.listeners  = entry_ff.listeners - LW'(1);
                  slot_we            = 1'b1;
                  rsp_in.count_after = entry_ff.count;
               end
            end
         endcase
      end
      slot_we      = slot_we && cmd.commit;
      wtr_we       = wtr_we && cmd.commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.commit) begin
         if (alloc) begin
            used_ff[slot_ff] <= 1'b1;
         end else if (release_slot) begin
            used_ff[slot_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && alloc) begin
         key_ff[slot_ff] <= req_ff.sem_key;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   `CSU_ASSERT_IMPLY(a_block_or_wake, cmd.commit, !(rsp_in.must_block && rsp_in.wake_valid))
   `CSU_ASSERT_NEXT(a_alloc_marks_used, cmd.commit && alloc, used_ff[slot_ff])

endmodule

// ----- hdl/counting_semaphore_table_unit.sv -----
// top level of the counting semaphore table unit
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_data  (kind, key, init, pid)
//   rsp_      out        rsp_valid/rsp_stall   rsp_data  (status, block, wake, count)
//
// one item at a time: accepted in idle, then lookup, read and exec states, then rsp_valid rises
// the sequence holds two registered ram reads in series (slot record, then waiter pid)
// reset clears the sequencer state and the slot-used flags; records are rewritten by open
// req_stall stays high from accept until the result item is taken
`timescale 1ns / 1ps
module counting_semaphore_table_unit import csu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // commands from sequencer to datapath
   cmd_type cmd;

   // sequencer: owns both handshakes
   csu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd)
   );

   // datapath: key match, slot record ram, waiter fifo ram, result register
   csu_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

endmodule

// ----- dv/counting_semaphore_table_unit_tb.sv -----
// self-checking testbench of the counting semaphore table unit
`timescale 1ns / 1ps
module counting_semaphore_table_unit_tb;
   import csu_pkg::*;

   localparam int DIRECTED_ITEMS = 25;
   localparam int RANDOM_ITEMS   = 750;
   localparam int PHASE_LEN      = 250;
   localparam int KEY_POOL_SIZE  = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;

   // dut ports; the inputs are known from time zero
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   counting_semaphore_table_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // items waiting to be offered, and outcomes waiting for their result item
   req_type request_backlog[$];
   rsp_type pending_outcomes[$];
   int      accepted_count = 0;
   int      mismatches     = 0;

   // shadow copy of the semaphore table
   bit          slot_live[NUM_SLOTS];
   logic [15:0] slot_key[NUM_SLOTS];
   logic [15:0] slot_count[NUM_SLOTS];
   int          slot_listeners[NUM_SLOTS];
   int          slot_waiting[NUM_SLOTS];
   int          slot_head[NUM_SLOTS];
   logic [15:0] waiter_pid[NUM_SLOTS][MAX_WAITERS];

   logic [15:0] key_pool[KEY_POOL_SIZE];

   // outcome of one request, updating the shadow table
   function automatic rsp_type semaphore_outcome(req_type rq);
      rsp_type r;
      int      s;
      int      pos;
      r = '0;
      s = -1;
      // lowest-numbered live slot holding the key wins
      for (int i = NUM_SLOTS - 1; i >= 0; i--)
         if (slot_live[i] && slot_key[i] == rq.sem_key) s = i;
      if (rq.kind == KIND_OPEN) begin
         if (s < 0) begin
            // allocate the lowest free slot
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
               if (!slot_live[i]) s = i;
            if (s >= 0) begin
               slot_live[s]      = 1'b1;
               slot_key[s]       = rq.sem_key;
               slot_count[s]     = rq.init_value;
               slot_listeners[s] = 0;
               slot_waiting[s]   = 0;
               slot_head[s]      = 0;
            end
         end
         if (s < 0) begin
            r.status = ST_TABLE_FULL;
         end else begin
            if (slot_listeners[s] >= MAX_WAITERS) r.status = ST_NO_SPACE;
            else slot_listeners[s]++;
            r.count_after = slot_count[s];
         end
      end else if (s < 0) begin
         r.status = ST_NOT_FOUND;
      end else if (rq.kind == KIND_WAIT) begin
         if (slot_count[s] != 16'd0) begin
            slot_count[s]--;
         end else if (slot_waiting[s] >= MAX_WAITERS) begin
            r.status = ST_NO_SPACE;
         end else begin
            pos = (slot_head[s] + slot_waiting[s]) % MAX_WAITERS;
            waiter_pid[s][pos] = rq.caller_pid;
            slot_waiting[s]++;
            r.must_block = 1'b1;
         end
         r.count_after = slot_count[s];
      end else if (rq.kind == KIND_POST) begin
         if (slot_waiting[s] > 0) begin
            r.wake_valid = 1'b1;
            r.wake_pid   = waiter_pid[s][slot_head[s]];
            slot_head[s] = (slot_head[s] + 1) % MAX_WAITERS;
            slot_waiting[s]--;
         end else if (slot_count[s] != 16'hFFFF) begin
            slot_count[s]++;
         end
         r.count_after = slot_count[s];
      end else begin
         // last close frees the slot and silently drops any waiters
         if (slot_listeners[s] <= 1) begin
            slot_live[s]      = 1'b0;
            slot_listeners[s] = 0;
            slot_waiting[s]   = 0;
         end else begin
            slot_listeners[s]--;
            r.count_after = slot_count[s];
         end
      end
      return r;
   endfunction

   // idle rates follow the progress of the run: receiver-heavy, sender-heavy, none
   function automatic int sender_idle_pct();
      if (accepted_count < DIRECTED_ITEMS + PHASE_LEN) return 32;
      if (accepted_count < DIRECTED_ITEMS + 2 * PHASE_LEN) return 54;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (accepted_count < DIRECTED_ITEMS + PHASE_LEN) return 54;
      if (accepted_count < DIRECTED_ITEMS + 2 * PHASE_LEN) return 32;
      return 0;
   endfunction

   task automatic push_request(logic [1:0] kind, logic [15:0] key, logic [15:0] init,
                               logic [15:0] pid);
      req_type rq;
      rq.kind       = kind;
      rq.sem_key    = key;
      rq.init_value = init;
      rq.caller_pid = pid;
      request_backlog.push_back(rq);
   endtask

   task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // reset held high from time zero, then released
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: predict each accepted item, then offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_outcomes.push_back(semaphore_outcome(req_data));
            accepted_count <= accepted_count + 1;
         end
         // payload only moves once the current item is gone
         if (!req_valid || !req_stall) begin
            if (request_backlog.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
               req_data  <= request_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each taken result item and choose the next stall
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      int      hold_left;
      bit      hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $error("result item with no request outstanding");
               mismatches++;
            end else begin
               want = pending_outcomes.pop_front();
               compare_field("status", 16'(want.status), 16'(rsp_data.status));
               compare_field("must_block", 16'(want.must_block), 16'(rsp_data.must_block));
               compare_field("wake_valid", 16'(want.wake_valid), 16'(rsp_data.wake_valid));
               compare_field("wake_pid", want.wake_pid, rsp_data.wake_pid);
               compare_field("count_after", want.count_after, rsp_data.count_after);
            end
         end
         // one long hold-off early in the no-idle phase, sender keeps offering
         if (!hold_done && accepted_count == DIRECTED_ITEMS + 2 * PHASE_LEN + 20) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int          pick;
      int          open_w;
      int          close_w;
      logic [1:0]  kind;
      logic [15:0] key;
      logic [15:0] init;

      // directed: not found, listener limit, full queue, wake order,
      // last close with waiters, count saturation
      push_request(KIND_WAIT, 16'h0000, 16'h0000, 16'h0000);
      for (int i = 0; i <= MAX_WAITERS; i++)
         push_request(KIND_OPEN, 16'h0000, 16'h8000, 16'(i));
      push_request(KIND_OPEN, 16'h5A5A, 16'h0000, 16'h1111);
      for (int i = 0; i <= MAX_WAITERS; i++)
         push_request(KIND_WAIT, 16'h5A5A, 16'hFFFF, (i == 0) ? 16'hFFFF : 16'(i * 257));
      push_request(KIND_POST, 16'h5A5A, 16'h0000, 16'h0000);
      push_request(KIND_CLOSE, 16'h5A5A, 16'h0000, 16'h0000);
      push_request(KIND_OPEN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_request(KIND_POST, 16'hFFFF, 16'h0000, 16'h0000);
      push_request(KIND_CLOSE, 16'hFFFF, 16'h0000, 16'h0000);

      // a small key pool so slots fill, queues build and the table runs out
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = 16'($urandom_range(0, 65535));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // alternate build-up and tear-down stretches so slots get freed
         if ((n / 60) % 2 == 0) begin
            open_w  = 30;
            close_w = 8;
         end else begin
            open_w  = 10;
            close_w = 30;
         end
         pick = $urandom_range(0, 99);
         if (pick < open_w) kind = KIND_OPEN;
         else if (pick < 100 - close_w - (100 - open_w - close_w) / 2) kind = KIND_WAIT;
         else if (pick < 100 - close_w) kind = KIND_POST;
         else kind = KIND_CLOSE;

         if ($urandom_range(0, 9) == 0) key = 16'($urandom_range(0, 65535));
         else key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];

         pick = $urandom_range(0, 99);
         if (pick < 60) init = 16'($urandom_range(0, 2));
         else if (pick < 75) init = 16'($urandom_range(65533, 65535));
         else init = 16'($urandom_range(0, 65535));

         push_request(kind, key, init, 16'($urandom_range(0, 65535)));
      end

      // drain, sampled away from the active edge
      while (!(accepted_count == DIRECTED_ITEMS + RANDOM_ITEMS
               && pending_outcomes.size() == 0))
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_outcomes.size() != 0) begin
         $error("expected result items never arrived: %0d", pending_outcomes.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- counting_semaphore_table_unit.f -----
+incdir+hdl
hdl/csu_pkg.sv
hdl/csu_ram.sv
hdl/csu_ctrl.sv
hdl/csu_dp.sv
hdl/counting_semaphore_table_unit.sv
dv/counting_semaphore_table_unit_tb.sv
